// ===== sv/gbn_pkg.sv =====
`default_nettype none
package gbn_pkg;

  // Datapath sizing.
  localparam int SEQ_BITS    = 32;
  localparam int WINDOW_BITS = 16;
  localparam int SUM_BITS    = ((SEQ_BITS > WINDOW_BITS) ? SEQ_BITS : WINDOW_BITS) + 1;

  // Fixed field widths.
  localparam int ACK_BITS     = 32;
  localparam int AWIN_BITS    = 16;
  localparam int WIN_EXT_BITS = (WINDOW_BITS > AWIN_BITS) ? WINDOW_BITS : AWIN_BITS;
  localparam int TIMEOUT_BITS = 16;
  localparam int RETRY_BITS   = 8;
  localparam int COUNT_BITS   = 32;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(100);
  localparam logic [RETRY_BITS-1:0]   RETRY_RESET   = RETRY_BITS'(5);
  localparam logic [AWIN_BITS-1:0]    INIT_WIN_RESET = AWIN_BITS'(32);

  typedef enum logic [1:0] {
    MODE_SEND    = 2'd0,
    MODE_ACK     = 2'd1,
    MODE_TICK    = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_TOTAL_PACKETS  = 2'd0,
    CFG_TIMEOUT_TICKS  = 2'd1,
    CFG_RETRY_LIMIT    = 2'd2,
    CFG_INITIAL_WINDOW = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    mode_t                mode;
    logic [ACK_BITS-1:0]  ack_number;
    logic [AWIN_BITS-1:0] ack_window;
  } item_t;

  typedef struct packed {
    logic                  send_valid;
    logic [31:0]           send_sequence;
    logic [31:0]           window_base_out;
    logic                  done_res;
    logic                  failed;
    logic [COUNT_BITS-1:0] retransmit_count;
  } result_t;

  typedef struct packed {
    cfg_idx_t                 index;
    logic [CFG_DATA_BITS-1:0] value;
  } cfg_write_t;

  // Advertised window brought to the internal window width.
  function automatic logic [WINDOW_BITS-1:0] to_window(input logic [AWIN_BITS-1:0] w);
    logic [WIN_EXT_BITS-1:0] ext;
    ext = WIN_EXT_BITS'(w);
    return WINDOW_BITS'(ext);
  endfunction

endpackage
`default_nettype wire

// ===== sv/gbn_item_if.sv =====
`default_nettype none
interface gbn_item_if
  import gbn_pkg::*;
  ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/gbn_result_if.sv =====
`default_nettype none
interface gbn_result_if
  import gbn_pkg::*;
  ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/gbn_cfg_if.sv =====
`default_nettype none
interface gbn_cfg_if
  import gbn_pkg::*;
  ();
  logic       valid;
  logic       ready;
  cfg_write_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/go_back_n_sender_window_top.sv =====
// Channel   Modport  Payload                                    Transfer when
// item      sink     mode, ack_number, ack_window               item.valid & item.ready
// result    source   send_valid, send_sequence, window_base_out, result.valid & result.ready
//                    done_res, failed, retransmit_count
// cfg       sink     index, value                               cfg.valid & cfg.ready
//
// One item per cycle while item.ready is high; each item yields one registered result.
// The window state updates from the item and the current state when the item is taken.
// A two-entry output queue (result register plus skid register) lets the block take
// one more item while a result waits; item.ready falls only when both entries are full.
// rst is synchronous and active high; it loads the register defaults, clears the
// window state and sets current_window from INIT_WIN_RESET. cfg.ready is always high.
`default_nettype none
module go_back_n_sender_window_top
  import gbn_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  gbn_item_if.sink     item,
  gbn_result_if.source result,
  gbn_cfg_if.sink      cfg
);

  // Configuration registers.
  logic [SEQ_BITS-1:0]     total_packets;
  logic [TIMEOUT_BITS-1:0] timeout_ticks;
  logic [RETRY_BITS-1:0]   retry_limit;
  logic [AWIN_BITS-1:0]    initial_window;

  // Window state.
  logic [SEQ_BITS-1:0]     window_base, window_base_next;
  logic [SEQ_BITS-1:0]     next_to_send, next_to_send_next;
  logic [WINDOW_BITS-1:0]  current_window, current_window_next;
  logic [RETRY_BITS-1:0]   retry_count, retry_count_next;
  logic [TIMEOUT_BITS-1:0] idle_ticks, idle_ticks_next;
  logic [COUNT_BITS-1:0]   rewinds, rewinds_next;
  logic                    fail_flag, fail_flag_next;

  // Output queue.
  logic    out_valid, skid_valid;
  result_t out_data, skid_data;
  result_t res_next;

  logic accept, out_take, cfg_write;

  assign item.ready  = !skid_valid;
  assign accept      = item.valid && item.ready;
  assign out_take    = out_valid && result.ready;
  assign cfg.ready   = 1'b1;
  assign cfg_write   = cfg.valid;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Per-item update.
  logic                    done_now;
  logic [ACK_BITS-1:0]     ack_clamped;
  logic [SEQ_BITS-1:0]     ack_seq;
  logic [SUM_BITS-1:0]     window_end;
  logic [TIMEOUT_BITS:0]   idle_inc;
  logic [RETRY_BITS:0]     retry_inc;
  logic                    send_ok;

  always_comb begin
    done_now    = window_base >= total_packets;
    ack_clamped = (item.data.ack_number > ACK_BITS'(total_packets))
                  ? ACK_BITS'(total_packets) : item.data.ack_number;
    ack_seq     = SEQ_BITS'(ack_clamped);
    window_end  = SUM_BITS'(window_base) + SUM_BITS'(current_window);
    send_ok     = (SUM_BITS'(next_to_send) < window_end) && (next_to_send < total_packets);
    idle_inc    = {1'b0, idle_ticks} + 1'b1;
    retry_inc   = {1'b0, retry_count} + 1'b1;

    window_base_next    = window_base;
    next_to_send_next   = next_to_send;
    current_window_next = current_window;
    retry_count_next    = retry_count;
    idle_ticks_next     = idle_ticks;
    rewinds_next        = rewinds;
    fail_flag_next      = fail_flag;
    res_next.send_valid    = 1'b0;
    res_next.send_sequence = '0;

    unique case (item.data.mode)
      MODE_RESTART: begin
        window_base_next    = '0;
        next_to_send_next   = '0;
        current_window_next = to_window(initial_window);
        retry_count_next    = '0;
        idle_ticks_next     = '0;
        rewinds_next        = '0;
        fail_flag_next      = 1'b0;
      end
      MODE_SEND: begin
        if (!fail_flag && send_ok) begin
          res_next.send_valid    = 1'b1;
          res_next.send_sequence = 32'(next_to_send);
          next_to_send_next      = next_to_send + 1'b1;
        end
      end
      MODE_ACK: begin
        if (!fail_flag && (ack_seq > window_base)) begin
          window_base_next    = ack_seq;
          next_to_send_next   = (next_to_send < ack_seq) ? ack_seq : next_to_send;
          current_window_next = to_window(item.data.ack_window);
          retry_count_next    = '0;
          idle_ticks_next     = '0;
        end
      end
      MODE_TICK: begin
        // Ticks do nothing once every packet has been acknowledged.
        if (!fail_flag && !done_now) begin
          if (idle_inc > {1'b0, timeout_ticks}) begin
            retry_count_next = retry_inc[RETRY_BITS] ? '1 : retry_inc[RETRY_BITS-1:0];
            idle_ticks_next  = '0;
            if (retry_inc > {1'b0, retry_limit}) begin
              fail_flag_next = 1'b1;
            end else begin
              next_to_send_next = window_base;
              if (rewinds != '1) begin
                rewinds_next = rewinds + 1'b1;
              end
            end
          end else begin
            idle_ticks_next = idle_inc[TIMEOUT_BITS] ? '1 : idle_inc[TIMEOUT_BITS-1:0];
          end
        end
      end
      default: ;
    endcase

    res_next.window_base_out  = 32'(window_base_next);
    res_next.done_res         = window_base_next >= total_packets;
    res_next.failed           = fail_flag_next;
    res_next.retransmit_count = rewinds_next;
  end

  // Configuration and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_packets  <= '0;
      timeout_ticks  <= TIMEOUT_RESET;
      retry_limit    <= RETRY_RESET;
      initial_window <= INIT_WIN_RESET;
      window_base    <= '0;
      next_to_send   <= '0;
      current_window <= to_window(INIT_WIN_RESET);
      retry_count    <= '0;
      idle_ticks     <= '0;
      rewinds        <= '0;
      fail_flag      <= 1'b0;
    end else begin
      if (accept) begin
        window_base    <= window_base_next;
        next_to_send   <= next_to_send_next;
        retry_count    <= retry_count_next;
        idle_ticks     <= idle_ticks_next;
        rewinds        <= rewinds_next;
        fail_flag      <= fail_flag_next;
      end
      // A write of initial_window loads the current window as well.
      if (cfg_write && (cfg.data.index == CFG_INITIAL_WINDOW)) begin
        current_window <= to_window(cfg.data.value[AWIN_BITS-1:0]);
      end else if (accept) begin
        current_window <= current_window_next;
      end
      if (cfg_write) begin
        unique case (cfg.data.index)
          CFG_TOTAL_PACKETS:  total_packets  <= SEQ_BITS'(cfg.data.value);
          CFG_TIMEOUT_TICKS:  timeout_ticks  <= cfg.data.value[TIMEOUT_BITS-1:0];
          CFG_RETRY_LIMIT:    retry_limit    <= cfg.data.value[RETRY_BITS-1:0];
          CFG_INITIAL_WINDOW: initial_window <= cfg.data.value[AWIN_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // Output queue control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (!out_valid || result.ready) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  // Output queue payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid || result.ready) begin
        out_data <= res_next;
      end else begin
        skid_data <= res_next;
      end
    end else if (out_take && skid_valid) begin
      out_data <= skid_data;
    end
  end

`ifndef SYNTHESIS
  // The skid entry only fills behind a waiting result.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output register is empty");

  // Nothing can be sent past the oldest unacknowledged sequence's left side.
  assert property (@(posedge clk) disable iff (rst) window_base <= next_to_send)
    else $error("next_to_send fell below window_base");

  // A failed transfer never sends.
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.data.send_valid) |-> !result.data.failed)
    else $error("send reported while the transfer is failed");

  // The failure flag only moves when an item is taken.
  assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(fail_flag))
    else $error("fail_flag changed without an item transfer");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_go_back_n_sender_window_top.sv =====
`default_nettype none
module tb_go_back_n_sender_window_top;
  import gbn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 60;

  logic clk = 1'b0;
  logic rst;

  gbn_item_if   item_ch ();
  gbn_result_if result_ch ();
  gbn_cfg_if    cfg_ch ();

  go_back_n_sender_window_top u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stimulus queues, expected results and run statistics.
  item_t      pending_items[$];
  cfg_write_t pending_writes[$];
  result_t    expected_results[$];

  int unsigned errors         = 0;
  int unsigned cycle_count    = 0;
  int unsigned items_seen     = 0;
  int unsigned results_seen   = 0;
  int unsigned packets_sent   = 0;
  int unsigned fail_events    = 0;
  int unsigned settings_used  = 0;

  bit   tx_steady = 1'b0;
  bit   rx_steady = 1'b0;
  logic hold_rx   = 1'b0;

  int unsigned tx_gap;
  int unsigned rx_pause;

  // Window state as the block should hold it.
  logic [31:0] reg_total;
  logic [15:0] reg_timeout;
  logic [7:0]  reg_retry_limit;
  logic [15:0] reg_init_window;

  logic [31:0] win_base;
  logic [31:0] next_seq;
  logic [15:0] win_size;
  logic [7:0]  retries;
  logic [15:0] idle_cnt;
  logic [31:0] rewind_cnt;
  logic        failed_st;

  function automatic int unsigned draw_pause(bit steady);
    return steady ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic void clear_window();
    win_base   = '0;
    next_seq   = '0;
    win_size   = reg_init_window;
    retries    = '0;
    idle_cnt   = '0;
    rewind_cnt = '0;
    failed_st  = 1'b0;
  endfunction

  function automatic result_t step_window(item_t it);
    result_t     r;
    logic        was_done;
    logic [31:0] ack;
    logic [16:0] idle_nx;
    logic [8:0]  retry_nx;
    r = '0;
    was_done = (win_base >= reg_total);
    if (it.mode == MODE_RESTART) begin
      clear_window();
    end else if (!failed_st) begin
      case (it.mode)
        MODE_SEND: begin
          if ({1'b0, next_seq} < {1'b0, win_base} + {17'd0, win_size} &&
              next_seq < reg_total) begin
            r.send_valid    = 1'b1;
            r.send_sequence = next_seq;
            next_seq        = next_seq + 32'd1;
          end
        end
        MODE_ACK: begin
          ack = (it.ack_number > reg_total) ? reg_total : it.ack_number;
          if (ack > win_base) begin
            win_base = ack;
            if (next_seq < win_base) next_seq = win_base;
            win_size = it.ack_window;
            retries  = '0;
            idle_cnt = '0;
          end
        end
        default: begin
          // Once everything is acknowledged the timer no longer runs.
          if (!was_done) begin
            idle_nx = {1'b0, idle_cnt} + 17'd1;
            if (idle_nx > {1'b0, reg_timeout}) begin
              retry_nx = {1'b0, retries} + 9'd1;
              retries  = (retry_nx > 9'd255) ? 8'hFF : retry_nx[7:0];
              idle_cnt = '0;
              if (retry_nx > {1'b0, reg_retry_limit}) begin
                failed_st = 1'b1;
                fail_events++;
              end else begin
                next_seq = win_base;
                if (rewind_cnt != '1) rewind_cnt = rewind_cnt + 32'd1;
              end
            end else begin
              idle_cnt = (idle_nx > 17'hFFFF) ? 16'hFFFF : idle_nx[15:0];
            end
          end
        end
      endcase
    end
    r.window_base_out  = win_base;
    r.done_res         = (win_base >= reg_total);
    r.failed           = failed_st;
    r.retransmit_count = rewind_cnt;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Item driver: one item per transfer, then a drawn number of idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      tx_gap        <= 0;
    end else if (!item_ch.valid || item_ch.ready) begin
      if (tx_gap != 0) begin
        item_ch.valid <= 1'b0;
        tx_gap        <= tx_gap - 1;
      end else if (pending_items.size() != 0) begin
        item_ch.data  <= pending_items.pop_front();
        item_ch.valid <= 1'b1;
        tx_gap        <= draw_pause(tx_steady);
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cfg_ch.valid <= 1'b0;
    end else if (!cfg_ch.valid || cfg_ch.ready) begin
      if (pending_writes.size() != 0) begin
        cfg_ch.data  <= pending_writes.pop_front();
        cfg_ch.valid <= 1'b1;
      end else begin
        cfg_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stalls a drawn number of cycles after each transfer, or
  // for a long stretch while hold_rx is up.
  always @(posedge clk) begin
    int unsigned pause;
    if (rst) begin
      result_ch.ready <= 1'b0;
      rx_pause        <= 0;
    end else if (hold_rx) begin
      result_ch.ready <= 1'b0;
    end else if (result_ch.valid && result_ch.ready) begin
      pause           = draw_pause(rx_steady);
      rx_pause        <= pause;
      result_ch.ready <= (pause == 0);
    end else if (rx_pause != 0) begin
      rx_pause        <= rx_pause - 1;
      result_ch.ready <= (rx_pause == 1);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Monitor: checks each result against the oldest expectation, then
  // predicts the result of any item transferred at this edge.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      reg_total       = '0;
      reg_timeout     = TIMEOUT_RESET;
      reg_retry_limit = RETRY_RESET;
      reg_init_window = INIT_WIN_RESET;
      clear_window();
      expected_results.delete();
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no item outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("send_valid", 32'(want.send_valid), 32'(result_ch.data.send_valid));
          check_field("send_sequence", want.send_sequence, result_ch.data.send_sequence);
          check_field("window_base_out", want.window_base_out,
                      result_ch.data.window_base_out);
          check_field("done_res", 32'(want.done_res), 32'(result_ch.data.done_res));
          check_field("failed", 32'(want.failed), 32'(result_ch.data.failed));
          check_field("retransmit_count", want.retransmit_count,
                      result_ch.data.retransmit_count);
          results_seen++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.index)
          CFG_TOTAL_PACKETS:  reg_total       = cfg_ch.data.value;
          CFG_TIMEOUT_TICKS:  reg_timeout     = cfg_ch.data.value[15:0];
          CFG_RETRY_LIMIT:    reg_retry_limit = cfg_ch.data.value[7:0];
          CFG_INITIAL_WINDOW: begin
            reg_init_window = cfg_ch.data.value[15:0];
            win_size        = reg_init_window;
          end
          default: ;
        endcase
      end
      if (item_ch.valid && item_ch.ready) begin
        want = step_window(item_ch.data);
        expected_results.push_back(want);
        items_seen++;
        if (want.send_valid) packets_sent++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("go_back_n_sender_window_top verification failed");
      $finish;
    end
  end

  task automatic queue_item(mode_t m, logic [31:0] ack, logic [15:0] awin);
    item_t it;
    it.mode       = m;
    it.ack_number = ack;
    it.ack_window = awin;
    pending_items.push_back(it);
  endtask

  task automatic queue_send();
    queue_item(MODE_SEND, $urandom, 16'($urandom_range(1, 65535)));
  endtask

  task automatic queue_tick();
    queue_item(MODE_TICK, $urandom, 16'($urandom_range(1, 65535)));
  endtask

  task automatic queue_restart();
    queue_item(MODE_RESTART, $urandom, 16'($urandom_range(1, 65535)));
  endtask

  // Waits until every item has been transferred and answered, then lets the
  // block's pipeline drain before anything else happens.
  task automatic settle();
    do @(negedge clk);
    while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0 ||
           pending_writes.size() != 0 || cfg_ch.valid);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_regs(logic [31:0] total, logic [15:0] tmo, logic [7:0] lim,
                          logic [15:0] win);
    cfg_write_t w;
    w.index = CFG_TOTAL_PACKETS;
    w.value = total;
    pending_writes.push_back(w);
    w.index = CFG_TIMEOUT_TICKS;
    w.value = 32'(tmo);
    pending_writes.push_back(w);
    w.index = CFG_RETRY_LIMIT;
    w.value = 32'(lim);
    pending_writes.push_back(w);
    w.index = CFG_INITIAL_WINDOW;
    w.value = 32'(win);
    pending_writes.push_back(w);
    do @(negedge clk);
    while (pending_writes.size() != 0 || cfg_ch.valid);
    settings_used++;
  endtask

  // Mostly a plausible transfer: sends, acks that creep forward, bursts of ticks
  // (long enough to time out when the timeout is short), and the odd stale or wild ack or restart.
  task automatic gen_traffic(int unsigned count, logic [31:0] total, logic [15:0] tmo);
    logic [31:0] seq_hi;
    logic [31:0] ack;
    logic [15:0] awin;
    int unsigned pick;
    int unsigned burst;
    seq_hi = '0;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        queue_send();
      end else if (pick < 72) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          ack = seq_hi + $urandom_range(0, 6);
          if (ack > seq_hi) seq_hi = ack;
        end else if (pick < 8) begin
          ack = $urandom_range(0, seq_hi);
        end else begin
          ack = $urandom;
        end
        awin = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535))
                                           : 16'($urandom_range(1, 12));
        queue_item(MODE_ACK, ack, awin);
      end else if (pick < 96) begin
        burst = $urandom_range(1, (tmo < 8) ? tmo + 2 : 4);
        repeat (burst) queue_tick();
      end else begin
        queue_restart();
        seq_hi = '0;
      end
      if (seq_hi >= total && $urandom_range(0, 3) == 0) begin
        queue_restart();
        seq_hi = '0;
      end
    end
  endtask

  initial begin
    logic [31:0] total;
    logic [15:0] tmo;
    logic [7:0]  lim;
    logic [15:0] win;

    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.data    = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    result_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Register defaults: an empty transfer is done from the start.
    queue_send();
    queue_tick();
    queue_item(MODE_ACK, 32'd5, 16'd3);
    queue_restart();
    settle();

    set_regs(32'd10, 16'd2, 8'd1, 16'd4);
    rx_steady = 1'b1;
    repeat (5) queue_send();
    queue_item(MODE_ACK, 32'd2, 16'd3);
    repeat (2) queue_send();
    queue_item(MODE_ACK, 32'd1, 16'd9);
    repeat (3) queue_tick();
    queue_send();
    // The second timeout exceeds a retry limit of one.
    repeat (3) queue_tick();
    queue_send();
    queue_item(MODE_ACK, 32'd9, 16'd9);
    queue_restart();
    // An ack past everything sent pulls the next sequence up to the new base.
    queue_item(MODE_ACK, 32'd7, 16'd2);
    repeat (3) queue_send();
    queue_item(MODE_ACK, 32'hFFFF_FFFF, 16'hFFFF);
    queue_tick();
    queue_restart();
    settle();

    // A zero timeout fires on the first tick; a zero window stalls sending.
    rx_steady = 1'b0;
    set_regs(32'd10, 16'd0, 8'd1, 16'd0);
    queue_send();
    repeat (2) queue_tick();
    queue_restart();
    queue_send();
    queue_item(MODE_ACK, 32'd4, 16'd0);
    queue_send();
    queue_item(MODE_ACK, 32'd5, 16'd3);
    repeat (2) queue_send();
    settle();

    // Drive the retry count to its ceiling before the transfer fails.
    tx_steady = 1'b1;
    set_regs(32'hFFFF_FFFE, 16'd1, 8'd255, 16'hFFFF);
    repeat (2) queue_send();
    for (int unsigned k = 0; k < 2 * 257; k++) begin
      queue_tick();
      if ($urandom_range(0, 15) == 0) queue_send();
    end
    queue_send();
    queue_restart();
    settle();

    for (int unsigned p = 0; p < 8; p++) begin
      total = $urandom_range(3, 300);
      tmo   = 16'($urandom_range(1, 10));
      lim   = 8'($urandom_range(0, 4));
      win   = 16'($urandom_range(1, 20));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        total = 32'd1;
        tmo   = 16'd1;
        lim   = 8'd0;
        win   = 16'd1;
      end else if (p == 1) begin
        total = 32'hFFFF_FFFE;
        tmo   = 16'hFFFF;
        lim   = 8'hFF;
        win   = 16'hFFFF;
      end else if (p == 5) begin
        total = $urandom;
        if (total == 32'hFFFF_FFFF) total = 32'hFFFF_FFFE;
      end
      set_regs(total, tmo, lim, win);
      if (p == 2) begin
        // The sender keeps offering while the receiver refuses everything, so
        // the block's output fills and it stops taking items.
        tx_steady = 1'b1;
        fork
          begin
            @(posedge clk);
            hold_rx <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_rx <= 1'b0;
          end
        join_none
      end
      gen_traffic(85, total, tmo);
      settle();
    end

    $display("Checked %0d results for %0d items over %0d register settings.",
             results_seen, items_seen, settings_used);
    $display("Predicted %0d packet sends and %0d transfers ending in failure.",
             packets_sent, fail_events);
    if (errors == 0) begin
      $display("go_back_n_sender_window_top verification clean");
    end else begin
      $display("go_back_n_sender_window_top verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/gbn_pkg.sv
sv/gbn_item_if.sv
sv/gbn_result_if.sv
sv/gbn_cfg_if.sv
sv/go_back_n_sender_window_top.sv
tb/tb_go_back_n_sender_window_top.sv
